@@ hdl/ule_pkg.sv @@
// package for the uuencode line encoder
// types, command/status structs and character constants; no dependencies
package ule_pkg;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_GRP,
        ST_SEQ,
        ST_EMPTY
    } t_state;

    // kind of result loaded into the output register
    typedef enum logic [1:0] {
        K_LEN,
        K_GRP,
        K_SEQ,
        K_EMPTY
    } t_kind;

    // controller to datapath commands
    typedef struct packed {
        logic       wr_byte;    // store accepted byte at the fill position
        logic       inc_held;   // advance the fill position
        logic       clr_held;   // line taken, restart fill position
        logic       set_len;    // latch the line length
        logic       len_full;   // length is a full line, else bytes held
        logic       ptr_clr;    // restart group pointer
        logic       ptr_adv;    // step group pointer by one group
        logic       rd;         // issue memory read
        logic [1:0] rd_slot;    // byte of the group being read
        logic       cap;        // capture read data into group register
        logic [1:0] cap_slot;   // byte of the group being captured
        logic       load;       // load output register
        t_kind      kind;       // what to load
        logic       last;       // final result of this request
        logic       seq_adv;    // advance sequence letter
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic held_last;  // next data byte completes the line
        logic held_zero;  // no bytes buffered
        logic grp_more;   // another group follows the current one
        logic out_free;   // output register can take a result
    } t_dp_status;

    localparam logic [6:0] CHAR_BIAS = 7'd32;
    localparam logic [6:0] CHAR_NL   = 7'd10;
    localparam logic [6:0] CHAR_Z    = 7'd122;
    localparam logic [4:0] SEQ_LAST  = 5'd25;

    // 6-bit value to printable character
    function automatic logic [6:0] enc6(input logic [5:0] v);
        enc6 = {1'b0, v} + CHAR_BIAS;
    endfunction

endpackage

@@ hdl/ule_in_if.sv @@
// request channel into the encoder: one data byte or a finish command
// no dependencies
interface ule_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

@@ hdl/ule_out_if.sv @@
// result channel out of the encoder: up to four ASCII characters per result
// no dependencies
interface ule_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_a;
    logic [6:0] char_b;
    logic [6:0] char_c;
    logic [6:0] char_d;
    logic [2:0] char_count;
    logic       run_last;

    modport source (output valid, output char_a, output char_b, output char_c,
                    output char_d, output char_count, output run_last, input ready);
    modport sink   (input valid, input char_a, input char_b, input char_c,
                    input char_d, input char_count, input run_last, output ready);
endinterface

@@ hdl/ule_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module ule_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 45
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ule_ctrl.sv @@
// controller of the uuencode line encoder: sequences buffering and line output
// depends on ule_pkg
module ule_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_cmd,
    output logic                o_in_ready,
    input  ule_pkg::t_dp_status i_status,
    output ule_pkg::t_ctrl_cmd  o_cmd
);

    ule_pkg::t_state r_state, n_state;
    logic            r_finish, n_finish;
    logic            w_accept;

    assign o_in_ready = (r_state == ule_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ule_pkg::ST_IDLE;
            r_finish <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_finish <= n_finish;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_finish = r_finish;
        o_cmd    = '0;
        o_cmd.kind = ule_pkg::K_LEN;
        unique case (r_state)
            ule_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (!i_in_cmd) begin
                        o_cmd.wr_byte = 1'b1;
                        if (i_status.held_last) begin
                            o_cmd.set_len  = 1'b1;
                            o_cmd.len_full = 1'b1;
                            o_cmd.clr_held = 1'b1;
                            n_finish       = 1'b0;
                            n_state        = ule_pkg::ST_LEN;
                        end else begin
                            o_cmd.inc_held = 1'b1;
                        end
                    end else begin
                        n_finish       = 1'b1;
                        o_cmd.clr_held = 1'b1;
                        if (i_status.held_zero) begin
                            n_state = ule_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.set_len = 1'b1;
                            n_state       = ule_pkg::ST_LEN;
                        end
                    end
                end
            end
            ule_pkg::ST_LEN: begin
                if (i_status.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = ule_pkg::K_LEN;
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = ule_pkg::ST_RD0;
                end
            end
            ule_pkg::ST_RD0: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_slot = 2'd0;
                n_state       = ule_pkg::ST_RD1;
            end
            ule_pkg::ST_RD1: begin
                o_cmd.rd       = 1'b1;
                o_cmd.rd_slot  = 2'd1;
                o_cmd.cap      = 1'b1;
                o_cmd.cap_slot = 2'd0;
                n_state        = ule_pkg::ST_RD2;
            end
            ule_pkg::ST_RD2: begin
                o_cmd.rd       = 1'b1;
                o_cmd.rd_slot  = 2'd2;
                o_cmd.cap      = 1'b1;
                o_cmd.cap_slot = 2'd1;
                n_state        = ule_pkg::ST_RD3;
            end
            ule_pkg::ST_RD3: begin
                o_cmd.cap      = 1'b1;
                o_cmd.cap_slot = 2'd2;
                n_state        = ule_pkg::ST_GRP;
            end
            ule_pkg::ST_GRP: begin
                if (i_status.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = ule_pkg::K_GRP;
                    o_cmd.ptr_adv = 1'b1;
                    n_state = i_status.grp_more ? ule_pkg::ST_RD0 : ule_pkg::ST_SEQ;
                end
            end
            ule_pkg::ST_SEQ: begin
                if (i_status.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = ule_pkg::K_SEQ;
                    o_cmd.last    = !r_finish;
                    o_cmd.seq_adv = 1'b1;
                    n_state = r_finish ? ule_pkg::ST_EMPTY : ule_pkg::ST_IDLE;
                end
            end
            ule_pkg::ST_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = ule_pkg::K_EMPTY;
                    o_cmd.last    = 1'b1;
                    o_cmd.seq_adv = 1'b1;
                    n_state       = ule_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ule_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/ule_dp.sv @@
// datapath of the uuencode line encoder: line memory, counters, group
// register and output register; depends on ule_pkg and ule_ram
module ule_dp #(
    parameter int LINE_BYTES = 45
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  ule_pkg::t_ctrl_cmd  i_cmd,
    output ule_pkg::t_dp_status o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [6:0]          o_char_a,
    output logic [6:0]          o_char_b,
    output logic [6:0]          o_char_c,
    output logic [6:0]          o_char_d,
    output logic [2:0]          o_char_count,
    output logic                o_run_last
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int HW = $clog2(LINE_BYTES + 1);
    localparam int PW = $clog2(LINE_BYTES + 4);

    logic [HW-1:0] r_held, r_len;
    logic [PW-1:0] r_ptr;
    logic [4:0]    r_seq;
    logic [7:0]    r_grp [3];
    logic          r_valid;
    logic [6:0]    r_a, r_b, r_c, r_d;
    logic [2:0]    r_cnt;
    logic          r_last;

    logic [PW-1:0] w_len_ext, w_ridx, w_cidx;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    logic [6:0]    w_letter;
    logic [5:0]    w_c1, w_c2, w_c3, w_c4;
    logic          w_out_free;

    // line memory
    ule_ram #(
        .WIDTH(8),
        .DEPTH(LINE_BYTES)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_byte),
        .i_waddr(r_held[AW-1:0]),
        .i_wdata(i_data_byte),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // group byte addressing, bytes past the line end read as zero
    assign w_len_ext = PW'(r_len);
    assign w_ridx    = r_ptr + PW'(i_cmd.rd_slot);
    assign w_cidx    = r_ptr + PW'(i_cmd.cap_slot);
    assign w_raddr   = (i_cmd.rd && (w_ridx < w_len_ext)) ? w_ridx[AW-1:0] : '0;

    // status to controller
    assign w_out_free         = !r_valid || i_out_ready;
    assign o_status.held_last = (r_held == HW'(LINE_BYTES - 1));
    assign o_status.held_zero = (r_held == '0);
    assign o_status.grp_more  = ((r_ptr + PW'(3)) < w_len_ext);
    assign o_status.out_free  = w_out_free;

    // character fields of one group
    assign w_c1     = r_grp[0][7:2];
    assign w_c2     = {r_grp[0][1:0], r_grp[1][7:4]};
    assign w_c3     = {r_grp[1][3:0], r_grp[2][7:6]};
    assign w_c4     = r_grp[2][5:0];
    assign w_letter = ule_pkg::CHAR_Z - {2'b00, r_seq};

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_seq   <= '0;
            r_ptr   <= '0;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_held) begin
                r_held <= '0;
            end else if (i_cmd.inc_held) begin
                r_held <= r_held + HW'(1);
            end
            if (i_cmd.set_len) begin
                r_len <= i_cmd.len_full ? HW'(LINE_BYTES) : r_held;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_adv) begin
                r_ptr <= r_ptr + PW'(3);
            end
            if (i_cmd.seq_adv) begin
                r_seq <= (r_seq == ule_pkg::SEQ_LAST) ? 5'd0 : r_seq + 5'd1;
            end
            if (i_cmd.load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // group byte capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_grp[i_cmd.cap_slot] <= (w_cidx < w_len_ext) ? w_rdata : 8'd0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_cmd.last;
            case (i_cmd.kind)
                ule_pkg::K_LEN: begin
                    r_a   <= ule_pkg::enc6(6'(r_len));
                    r_b   <= 7'd0;
                    r_c   <= 7'd0;
                    r_d   <= 7'd0;
                    r_cnt <= 3'd1;
                end
                ule_pkg::K_GRP: begin
                    r_a   <= ule_pkg::enc6(w_c1);
                    r_b   <= ule_pkg::enc6(w_c2);
                    r_c   <= ule_pkg::enc6(w_c3);
                    r_d   <= ule_pkg::enc6(w_c4);
                    r_cnt <= 3'd4;
                end
                ule_pkg::K_SEQ: begin
                    r_a   <= w_letter;
                    r_b   <= ule_pkg::CHAR_NL;
                    r_c   <= 7'd0;
                    r_d   <= 7'd0;
                    r_cnt <= 3'd2;
                end
                default: begin
                    r_a   <= ule_pkg::CHAR_BIAS;
                    r_b   <= w_letter;
                    r_c   <= ule_pkg::CHAR_NL;
                    r_d   <= 7'd0;
                    r_cnt <= 3'd3;
                end
            endcase
        end
    end

    assign o_out_valid  = r_valid;
    assign o_char_a     = r_a;
    assign o_char_b     = r_b;
    assign o_char_c     = r_c;
    assign o_char_d     = r_d;
    assign o_char_count = r_cnt;
    assign o_run_last   = r_last;

endmodule

@@ hdl/uuencode_line_encoder.sv @@
// uuencode line encoder: buffers raw bytes and emits encoded lines
// depends on ule_pkg, ule_in_if, ule_out_if, ule_ctrl, ule_dp, ule_ram
//
// Usage:
//   i_in carries requests: cmd 0 with a data byte, or cmd 1 to finish.
//   o_out carries results of one to four ASCII characters; run_last marks
//   the final result caused by a request.
//   A data byte that does not complete a line gives no result. The byte
//   that completes a line of LINE_BYTES bytes, and a finish with bytes held,
//   start line output: a length result, one result per three bytes, then the
//   sequence letter with a newline; a finish adds an empty line after it.
//   Each group takes three reads through the single read port of the line
//   memory into the group register, then the load into the output register.
//   Requests are taken only between lines; i_in.ready is low while a line is
//   going out. A result waits in the output register while the receiver
//   stalls and output resumes when it is taken.
//   Reset clears the byte count and sets the sequence letter to z; no
//   clearing pass over the line memory is needed.
module uuencode_line_encoder #(
    parameter int LINE_BYTES = 45
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ule_in_if.sink     i_in,
    ule_out_if.source  o_out
);

    ule_pkg::t_ctrl_cmd  w_cmd;
    ule_pkg::t_dp_status w_status;

    // sequencer
    ule_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_in_cmd  (i_in.cmd),
        .o_in_ready(i_in.ready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // buffer, counters and encoder
    ule_dp #(
        .LINE_BYTES(LINE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in.data_byte),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_char_a    (o_out.char_a),
        .o_char_b    (o_out.char_b),
        .o_char_c    (o_out.char_c),
        .o_char_d    (o_out.char_d),
        .o_char_count(o_out.char_count),
        .o_run_last  (o_out.run_last)
    );

`ifndef SYNTHESIS
    // every result holds one to four characters
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.char_count == 3'd1 || o_out.char_count == 3'd2 ||
                         o_out.char_count == 3'd3 || o_out.char_count == 3'd4))
        else $error("result character count out of range");

    // a finish request always starts output, so requests stop
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd) |=> !i_in.ready)
        else $error("finish did not start line output");

    // the byte that fills the line starts output
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.cmd && w_status.held_last) |=> !i_in.ready)
        else $error("full line did not start output");

    // a new result is loaded only when the output register is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_status.out_free)
        else $error("output register overwritten");
`endif

endmodule

@@ dv/ule_checker.sv @@
// shared testbench types and the result checker of the uuencode line encoder
// depends on ule_pkg, ule_in_if and ule_out_if
`timescale 1ns / 1ps

package ule_tb_pkg;

    localparam int LINE_LEN = 45;

    // request command carried with each byte
    typedef enum logic {
        CMD_DATA   = 1'b0,
        CMD_FINISH = 1'b1
    } t_req_cmd;

endpackage

module ule_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ule_in_if    i_req,
    ule_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    // character counts of the four kinds of result
    localparam logic [2:0] CNT_LEN   = 3'd1;
    localparam logic [2:0] CNT_SEQ   = 3'd2;
    localparam logic [2:0] CNT_EMPTY = 3'd3;
    localparam logic [2:0] CNT_GRP   = 3'd4;
    localparam int         REPORT_MAX = 10;

    typedef struct packed {
        logic [6:0] char_a;
        logic [6:0] char_b;
        logic [6:0] char_c;
        logic [6:0] char_d;
        logic [2:0] char_count;
        logic       run_last;
    } t_char_word;

    // predicted encoder state
    t_char_word coded_words[$];
    logic [7:0] line_buf [ule_tb_pkg::LINE_LEN];
    int         bytes_in_line = 0;
    logic [4:0] letter_idx = '0;
    int         mismatch_total = 0;
    int         compared_total = 0;

    // six-bit value to its printable character
    function automatic logic [6:0] printable(input logic [5:0] v);
        return 7'(v) + ule_pkg::CHAR_BIAS;
    endfunction

    // letter of the next line, counting down from z and wrapping after a
    function automatic logic [6:0] take_letter();
        logic [6:0] letter;
        letter = ule_pkg::CHAR_Z - 7'(letter_idx);
        letter_idx = (letter_idx == ule_pkg::SEQ_LAST) ? 5'd0 : letter_idx + 5'd1;
        return letter;
    endfunction

    function automatic void queue_word(input logic [6:0] a, input logic [6:0] b,
                                       input logic [6:0] c, input logic [6:0] d,
                                       input logic [2:0] cnt);
        coded_words.push_back('{a, b, c, d, cnt, 1'b0});
    endfunction

    // length, groups and sequence letter of a line of n bytes
    function automatic void queue_line(input int n);
        logic [7:0] b0, b1, b2;
        queue_word(printable(6'(n)), 7'd0, 7'd0, 7'd0, CNT_LEN);
        for (int i = 0; i < n; i += 3) begin
            // bytes past the end of the line count as zero
            b0 = line_buf[i];
            b1 = (i + 1 < n) ? line_buf[i + 1] : 8'h00;
            b2 = (i + 2 < n) ? line_buf[i + 2] : 8'h00;
            queue_word(printable(b0[7:2]), printable({b0[1:0], b1[7:4]}),
                       printable({b1[3:0], b2[7:6]}), printable(b2[5:0]), CNT_GRP);
        end
        queue_word(take_letter(), ule_pkg::CHAR_NL, 7'd0, 7'd0, CNT_SEQ);
    endfunction

    // expected results of one accepted request
    function automatic void predict_request(input logic cmd, input logic [7:0] req_byte);
        int words_before;
        words_before = coded_words.size();
        if (cmd == ule_tb_pkg::CMD_DATA) begin
            line_buf[bytes_in_line] = req_byte;
            bytes_in_line++;
            if (bytes_in_line == ule_tb_pkg::LINE_LEN) begin
                queue_line(ule_tb_pkg::LINE_LEN);
                bytes_in_line = 0;
            end
        end else begin
            if (bytes_in_line > 0) begin
                queue_line(bytes_in_line);
            end
            bytes_in_line = 0;
            queue_word(ule_pkg::CHAR_BIAS, take_letter(), ule_pkg::CHAR_NL, 7'd0,
                       CNT_EMPTY);
        end
        if (coded_words.size() > words_before) begin
            coded_words[coded_words.size() - 1].run_last = 1'b1;
        end
    endfunction

    function automatic void check_result(input t_char_word got);
        t_char_word want;
        if (coded_words.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_MAX) begin
                $display("%0t: unexpected result a=%h b=%h c=%h d=%h count=%0d last=%0d",
                         $time, got.char_a, got.char_b, got.char_c, got.char_d,
                         got.char_count, got.run_last);
            end
        end else begin
            want = coded_words.pop_front();
            compared_total++;
            if (got.char_a !== want.char_a || got.char_b !== want.char_b ||
                got.char_c !== want.char_c || got.char_d !== want.char_d ||
                got.char_count !== want.char_count || got.run_last !== want.run_last) begin
                mismatch_total++;
                if (mismatch_total <= REPORT_MAX) begin
                    $display("%0t: mismatch expected a=%h b=%h c=%h d=%h count=%0d last=%0d",
                             $time, want.char_a, want.char_b, want.char_c, want.char_d,
                             want.char_count, want.run_last);
                    $display("%0t:          actual a=%h b=%h c=%h d=%h count=%0d last=%0d",
                             $time, got.char_a, got.char_b, got.char_c, got.char_d,
                             got.char_count, got.run_last);
                end
            end
        end
    endfunction

    // requests are predicted before results are checked in the same cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bytes_in_line = 0;
            letter_idx = '0;
            coded_words.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.cmd, i_req.data_byte);
            end
            if (i_res.valid && i_res.ready) begin
                check_result('{i_res.char_a, i_res.char_b, i_res.char_c, i_res.char_d,
                               i_res.char_count, i_res.run_last});
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= coded_words.size();
        o_checked    <= compared_total;
    end

endmodule

@@ dv/tb_uuencode_line_encoder.sv @@
// testbench top of the uuencode line encoder: clock, reset, stimulus and verdict
// depends on ule_pkg, ule_tb_pkg, ule_checker, the interfaces and the encoder
`timescale 1ns / 1ps

module tb_uuencode_line_encoder;

    localparam int RANDOM_ITEMS = 100;
    localparam int CALM_ITEMS   = 25;    // closing requests sent with no idling
    localparam int MIN_FINISHES = 16;    // lowest number of finish commands in the run
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk;
    logic i_rst_n = 1'b0;

    ule_in_if  req_ch ();
    ule_out_if res_ch ();

    int req_gap_pct   = 30;
    int res_stall_pct = 30;
    int calm_from     = 32'h7fff_ffff;
    int sent_total    = 0;
    int finish_total  = 0;
    int fail_count;
    int pending;
    int checked;
    int quiet_cycles;

    uuencode_line_encoder #(
        .LINE_BYTES (ule_tb_pkg::LINE_LEN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    ule_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // byte values with the extremes weighted up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one request, with an optional idle burst ahead of it
    task automatic send_request(input ule_tb_pkg::t_req_cmd cmd, input logic [7:0] req_byte);
        if (sent_total >= calm_from) begin
            req_gap_pct   = 0;
            res_stall_pct = 0;
        end
        if ($urandom_range(1, 100) <= req_gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.data_byte <= req_byte;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_total++;
        if (cmd == ule_tb_pkg::CMD_FINISH) begin
            finish_total++;
        end
    endtask

    // receiver with random stall bursts
    initial begin
        res_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(1, 100) <= res_stall_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // watchdog on cycles with no request or result moving
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int random_base;
        int run_len;
        int run_no;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = ule_tb_pkg::CMD_DATA;
        req_ch.data_byte = 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // finish on an empty buffer gives only the empty line
        send_request(ule_tb_pkg::CMD_FINISH, 8'h00);
        // last group short by one byte
        send_request(ule_tb_pkg::CMD_DATA, 8'hff);
        send_request(ule_tb_pkg::CMD_DATA, 8'h00);
        send_request(ule_tb_pkg::CMD_FINISH, 8'hff);
        // last group short by two bytes
        send_request(ule_tb_pkg::CMD_DATA, 8'h80);
        send_request(ule_tb_pkg::CMD_FINISH, 8'h00);
        // two complete groups
        send_request(ule_tb_pkg::CMD_DATA, 8'h00);
        send_request(ule_tb_pkg::CMD_DATA, 8'hff);
        send_request(ule_tb_pkg::CMD_DATA, 8'h01);
        send_request(ule_tb_pkg::CMD_DATA, 8'hfe);
        send_request(ule_tb_pkg::CMD_DATA, 8'h55);
        send_request(ule_tb_pkg::CMD_DATA, 8'haa);
        send_request(ule_tb_pkg::CMD_FINISH, 8'h00);
        // back-to-back empty lines
        send_request(ule_tb_pkg::CMD_FINISH, 8'hff);
        send_request(ule_tb_pkg::CMD_FINISH, 8'h00);

        // random runs of bytes closed by a finish
        random_base = sent_total;
        calm_from   = random_base + RANDOM_ITEMS - CALM_ITEMS;
        run_no      = 0;
        while (sent_total - random_base < RANDOM_ITEMS || finish_total < MIN_FINISHES) begin
            if (sent_total < calm_from) begin
                case ($urandom_range(0, 2))
                    0:       begin req_gap_pct = 0;  res_stall_pct = 0;  end
                    1:       begin req_gap_pct = 25; res_stall_pct = 25; end
                    default: begin req_gap_pct = 60; res_stall_pct = 60; end
                endcase
            end
            if (run_no == 0) begin
                run_len = ule_tb_pkg::LINE_LEN;
            end else begin
                case ($urandom_range(0, 9))
                    0:       run_len = $urandom_range(ule_tb_pkg::LINE_LEN,
                                                      ule_tb_pkg::LINE_LEN + 5);
                    1, 2:    run_len = 0;
                    default: run_len = $urandom_range(1, 5);
                endcase
            end
            repeat (run_len) send_request(ule_tb_pkg::CMD_DATA, pick_byte());
            send_request(ule_tb_pkg::CMD_FINISH, pick_byte());
            run_no++;
        end
        req_ch.valid <= 1'b0;

        // drain outstanding results, then watch for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests (%0d finish commands) in %0d byte runs",
                 sent_total, finish_total, run_no);
        $display("%0d results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/ule_pkg.sv
hdl/ule_in_if.sv
hdl/ule_out_if.sv
hdl/ule_ram.sv
hdl/ule_ctrl.sv
hdl/ule_dp.sv
hdl/uuencode_line_encoder.sv
dv/ule_checker.sv
dv/tb_uuencode_line_encoder.sv
